### sv/tridiagonal_line_solver_core_assert.svh
// ---------------------------------------------------------------------------
// Tridiagonal line solver assertion macros
// Shared assertion wrappers; they vanish when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef TRIDIAGONAL_LINE_SOLVER_CORE_ASSERT_SVH
`define TRIDIAGONAL_LINE_SOLVER_CORE_ASSERT_SVH
`ifndef SYNTH
`define TLS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TLS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/tls_pkg.sv
// ---------------------------------------------------------------------------
// Tridiagonal line solver package
// Shared constants and saturation helpers for Q8.24 arithmetic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package tls_pkg;
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 24;
    localparam int MAX_LEN_DEFAULT = 64;
    localparam int POS_W   = 6;
    localparam logic [DATA_W-1:0] DIAG_RESET = 32'h0100_0000;
    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic REG_DIAG    = 1'b0;
    localparam logic REG_OFFDIAG = 1'b1;

    // Saturate a 66-bit signed value to 32 bits.
    function automatic logic [DATA_W-1:0] sat66(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sh0_7FFF_FFFF;
        lo = -66'sh0_8000_0000;
        if (x > hi) begin
            return Q_MAX;
        end else if (x < lo) begin
            return Q_MIN;
        end
        return x[DATA_W-1:0];
    endfunction
endpackage

### sv/tls_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/tridiagonal_line_solver_core.sv
// ---------------------------------------------------------------------------
// Tridiagonal line solver core
// Thomas algorithm on one line of a constant-coefficient system, Q8.24.
// ---------------------------------------------------------------------------
// Each right-hand-side beat is forward-eliminated as it arrives; the beat with
// tlast starts back substitution, which sends the unknowns from the highest
// position down to position 0, the last one with tlast. Every multiply runs
// bit-serially (one multiplier bit per cycle) and every divide is a restoring
// divider with one quotient bit per cycle; the first beat of a line takes no
// multiply or divide and every later beat two multiplies and two divides, and
// each result of back substitution but the first (highest position) costs
// one multiply and one divide. A zero pivot saturates and sets tuser on every
// result of that line.
`timescale 1ns / 1ps
module tridiagonal_line_solver_core
    import tls_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rhs_value[31:0]
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // solution[31:0], position[37:32], zero fill
    output logic        m_tlast,   // run_end
    output logic        m_tuser    // div_fault
);
`include "tridiagonal_line_solver_core_assert.svh"

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] LEN_C = CW'(MAX_LEN);

    typedef enum logic [4:0] {
        S_IDLE, S_FRD, S_FRW, S_FM1, S_FD1, S_FM2, S_FD2, S_FWR,
        S_BRD, S_BRW, S_BM, S_BSUB, S_BD, S_OUT
    } state_t;

    state_t          state_reg;
    logic [31:0]     diag_reg, offd_reg, a_line_reg;
    logic [31:0]     rhs_reg, pd_reg, pr_reg, t_reg, next_reg;
    logic [CW-1:0]   fill_reg;
    logic [AW-1:0]   idx_reg;
    logic            last_reg, first_reg, fault_reg;

    // serial multiplier: shift-add over |y|
    logic [63:0]     macc_reg, mcand_reg;
    logic [31:0]     mplier_reg;
    logic            mneg_reg;
    logic [5:0]      mcnt_reg;
    // serial divider: 56-bit |x|<<24 over 32-bit |y|
    logic [55:0]     dq_reg;
    logic [32:0]     drem_reg;
    logic [31:0]     dden_reg;
    logic            dneg_reg, dxneg_reg;
    logic [5:0]      dcnt_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [31:0]     d_rd, r_rd, d_wd, r_wd;

    tls_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_diag (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(d_wd),
        .raddr(ram_raddr), .rdata(d_rd));
    tls_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_rhs (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(r_wd),
        .raddr(ram_raddr), .rdata(r_rd));

    // Magnitudes for the serial units.
    function automatic logic [31:0] mag(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] qsub(input logic [31:0] x, input logic [31:0] y);
        logic signed [65:0] s;
        s = 66'(signed'(x)) - 66'(signed'(y));
        return sat66(s);
    endfunction

    // Multiply result: floor(p / 2^24) with saturation.
    logic [31:0] mul_res;
    always_comb begin
        logic signed [65:0] p;
        p = mneg_reg ? -66'(macc_reg) : 66'(macc_reg);
        mul_res = sat66(p >>> FRAC_W);
    end

    // Divide result: truncate toward zero, saturate; zero divisor handled apart.
    logic [31:0] div_res;
    always_comb begin
        logic signed [65:0] q;
        q = dneg_reg ? -66'(dq_reg) : 66'(dq_reg);
        if (dden_reg == 32'd0) begin
            div_res = dxneg_reg ? Q_MIN : Q_MAX;
        end else begin
            div_res = sat66(q);
        end
    end

    logic [32:0] dtrial;
    assign dtrial = {drem_reg[31:0], dq_reg[55]} - {1'b0, dden_reg};

    logic        mul_go, div_go;
    logic [31:0] mx, my, dx, dy;
    logic        s_acc, m_acc;
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign s_tready = (state_reg == S_IDLE);

    assign ram_raddr = idx_reg;
    assign ram_waddr = idx_reg;
    assign ram_we    = (state_reg == S_FWR);

    always_comb begin
        mul_go = 1'b0;
        div_go = 1'b0;
        mx = offd_reg; my = offd_reg;
        dx = t_reg;    dy = pd_reg;
        d_wd = diag_reg;
        r_wd = rhs_reg;
        if (!first_reg) begin
            d_wd = t_reg;
            r_wd = next_reg;
        end
        case (state_reg)
            S_FRW: begin mul_go = 1'b1; mx = offd_reg; my = offd_reg; end
            S_FM1: begin div_go = (mcnt_reg == 6'd0); dx = mul_res; end
            S_FD1: begin mul_go = (dcnt_reg == 6'd0); mx = offd_reg; my = pr_reg; end
            S_FM2: begin div_go = (mcnt_reg == 6'd0); dx = mul_res; end
            S_BRW: begin mul_go = 1'b1; mx = a_line_reg; my = next_reg; end
            S_BSUB: begin div_go = 1'b1; dx = t_reg; dy = pd_reg; end
            default: begin end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            diag_reg  <= DIAG_RESET;
            offd_reg  <= '0;
            fill_reg  <= '0;
            fault_reg <= 1'b0;
            m_tvalid  <= 1'b0;
            mcnt_reg  <= '0;
            dcnt_reg  <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_DIAG) begin
                    diag_reg <= cfg_wdata;
                end else begin
                    offd_reg <= cfg_wdata;
                end
            end
            // bit-serial multiply step
            if (mul_go) begin
                macc_reg   <= '0;
                mcand_reg  <= {32'd0, mag(mx)};
                mplier_reg <= mag(my);
                mneg_reg   <= mx[31] ^ my[31];
                mcnt_reg   <= 6'd32;
            end else if (mcnt_reg != 6'd0) begin
                if (mplier_reg[0]) begin
                    macc_reg <= macc_reg + mcand_reg;
                end
                mcand_reg  <= {mcand_reg[62:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[31:1]};
                mcnt_reg   <= mcnt_reg - 6'd1;
            end
            // restoring divide step
            if (div_go) begin
                dq_reg    <= {mag(dx), 24'd0};
                drem_reg  <= '0;
                dden_reg  <= mag(dy);
                dneg_reg  <= dx[31] ^ dy[31];
                dxneg_reg <= dx[31];
                dcnt_reg  <= 6'd56;
                if (dy == 32'd0) begin
                    fault_reg <= 1'b1;
                end
            end else if (dcnt_reg != 6'd0) begin
                if (!dtrial[32]) begin
                    drem_reg <= dtrial;
                    dq_reg   <= {dq_reg[54:0], 1'b1};
                end else begin
                    drem_reg <= {drem_reg[31:0], dq_reg[55]};
                    dq_reg   <= {dq_reg[54:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 6'd1;
            end
            if (m_acc) begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        rhs_reg   <= s_tdata;
                        last_reg  <= s_tlast;
                        a_line_reg <= offd_reg;
                        if (fill_reg == LEN_C) begin
                            // Line is full: the beat is dropped, but a last beat
                            // still starts back substitution at the top entry.
                            first_reg <= 1'b1;
                            state_reg <= s_tlast ? S_BRD : S_IDLE;
                            idx_reg   <= AW'(fill_reg - CW'(1));
                        end else if (fill_reg == '0) begin
                            first_reg <= 1'b1;
                            idx_reg   <= '0;
                            state_reg <= S_FWR;
                        end else begin
                            first_reg <= 1'b0;
                            idx_reg   <= AW'(fill_reg - CW'(1));
                            state_reg <= S_FRD;
                        end
                    end
                end
                S_FRD: state_reg <= S_FRW;
                S_FRW: begin
                    pd_reg <= d_rd;
                    pr_reg <= r_rd;
                    state_reg <= S_FM1;
                end
                S_FM1: if (mcnt_reg == 6'd0) state_reg <= S_FD1;
                S_FD1: if (dcnt_reg == 6'd0) begin
                    t_reg <= qsub(diag_reg, div_res);
                    state_reg <= S_FM2;
                end
                S_FM2: if (mcnt_reg == 6'd0) state_reg <= S_FD2;
                S_FD2: if (dcnt_reg == 6'd0) begin
                    next_reg <= qsub(rhs_reg, div_res);
                    idx_reg  <= AW'(fill_reg);
                    state_reg <= S_FWR;
                end
                S_FWR: begin
                    fill_reg <= fill_reg + CW'(1);
                    idx_reg  <= AW'(fill_reg);
                    first_reg <= 1'b1;
                    state_reg <= last_reg ? S_BRD : S_IDLE;
                end
                S_BRD: state_reg <= S_BRW;
                S_BRW: begin
                    pd_reg <= d_rd;
                    t_reg  <= r_rd;
                    state_reg <= first_reg ? S_BSUB : S_BM;
                end
                S_BM: if (mcnt_reg == 6'd0) begin
                    t_reg <= qsub(t_reg, mul_res);
                    state_reg <= S_BSUB;
                end
                S_BSUB: state_reg <= S_BD;
                S_BD: if (dcnt_reg == 6'd0 && !m_tvalid) begin
                    next_reg  <= div_res;
                    m_tdata   <= {2'b00, POS_W'(idx_reg), div_res};
                    m_tlast   <= (idx_reg == '0);
                    m_tuser   <= fault_reg || (dden_reg == 32'd0);
                    m_tvalid  <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_acc) begin
                    if (idx_reg == '0) begin
                        fill_reg  <= '0;
                        fault_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end else begin
                        idx_reg   <= idx_reg - AW'(1);
                        first_reg <= 1'b0;
                        state_reg <= S_BRD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `TLS_ASSERT_IMPL(a_no_in_busy, aclk, aresetn, state_reg != S_IDLE, !s_tready, "busy accept")
    `TLS_ASSERT_IMPL(a_fill_max, aclk, aresetn, 1'b1, fill_reg <= LEN_C, "fill overflow")
    `TLS_ASSERT_NEXT(a_end_clear, aclk, aresetn, m_acc && m_tlast, fill_reg == '0, "no clear")
    `TLS_ASSERT_IMPL(a_out_state, aclk, aresetn, m_tvalid, state_reg == S_OUT, "stray valid")
endmodule
